// ----- rtl/pwfc_pkg.sv -----
// Shared constants and types of the pixel weight and flag combiner.
`default_nettype none

package pwfc_pkg;

  localparam int WEIGHT_W   = 32;
  localparam int FLAG_IN_W  = 31;
  localparam int FLAG_OUT_W = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  // Remap slots: the first MAX_REMAP selected bits, at most four 16-bit masks
  localparam int MAX_REMAP   = 4;
  localparam int REMAP_SLOTS = 4;
  localparam int NUM_SLOTS   = (MAX_REMAP < REMAP_SLOTS) ? MAX_REMAP : REMAP_SLOTS;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_LOW       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_HIGH      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_FLAG_MASK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZERO_MASK = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_SELECT_MASK = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REMAP_WORDS      = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_FLAG_MASK   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT     = 8'd7;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0]         thresh_low;
    logic signed [WEIGHT_W-1:0]         thresh_high;
    logic [FLAG_OUT_W-1:0]              reject_flag_mask;
    logic [FLAG_IN_W-1:0]               weight_zero_mask;
    logic [FLAG_IN_W-1:0]               flag_select_mask;
    logic [REMAP_SLOTS*FLAG_OUT_W-1:0]  remap_words;
    logic [FLAG_OUT_W-1:0]              area_flag_mask;
    logic signed [WEIGHT_W-1:0]         weight_limit;
  } cfg_t;

  // Per-pixel result of the combine logic
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_out;
    logic [FLAG_OUT_W-1:0]      flag_out;
    logic                       area_hit;
    logic                       limit_hit;
  } pix_res_t;

endpackage

`default_nettype wire

// ----- rtl/pwfc_if.sv -----
// Channel interfaces: pixel input, result output and register write.
`default_nettype none

interface pwfc_in_if;
  import pwfc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight_in;
  logic [FLAG_IN_W-1:0]       flag_in;
  logic                       last_pixel;

  modport source (output valid, weight_in, flag_in, last_pixel, input ready);
  modport sink   (input valid, weight_in, flag_in, last_pixel, output ready);
endinterface

interface pwfc_out_if;
  import pwfc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight_out;
  logic [FLAG_OUT_W-1:0]      flag_out;
  logic [CNT_W-1:0]           flagged_count;
  logic [CNT_W-1:0]           weighted_count;
  logic                       image_done;

  modport source (output valid, weight_out, flag_out, flagged_count, weighted_count,
                  image_done, input ready);
  modport sink   (input valid, weight_out, flag_out, flagged_count, weighted_count,
                  image_done, output ready);
endinterface

interface pwfc_cfg_if;
  import pwfc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pixel_weight_flag_combiner_top.sv -----
// Top level of the pixel weight and flag combiner.
//
//   channel   direction  handshake        payload
//   in_bus    in         valid / ready    weight_in, flag_in, last_pixel
//   out_bus   out        valid / ready    weight_out, flag_out, flagged_count,
//                                         weighted_count, image_done
//   cfg_bus   in         valid / ready    index, data (ready always high)
//
// One pixel per cycle sustained while out_bus.ready is high; a pixel passes the input
// register, then the combine logic and counters into the result register.
// rst_n is synchronous: it empties both stages, clears the totals and loads
// the register reset values. A stalled result holds the result register; the
// input register still fills behind it, so ready drops only when both are full.
`default_nettype none

module pixel_weight_flag_combiner_top (
  input  logic     clk,
  input  logic     rst_n,
  pwfc_in_if.sink  in_bus,
  pwfc_out_if.source out_bus,
  pwfc_cfg_if.sink cfg_bus
);
  import pwfc_pkg::*;

  cfg_t     cfg;
  pix_res_t res;

  logic                       s1_valid_r;
  logic signed [WEIGHT_W-1:0] s1_weight_r;
  logic [FLAG_IN_W-1:0]       s1_flag_r;
  logic                       s1_last_r;

  logic                       out_valid_r;
  logic signed [WEIGHT_W-1:0] out_weight_r;
  logic [FLAG_OUT_W-1:0]      out_flag_r;
  logic [CNT_W-1:0]           out_fcnt_r;
  logic [CNT_W-1:0]           out_wcnt_r;
  logic                       out_done_r;

  logic             out_adv;
  logic             s1_adv;
  logic             upd;
  logic [CNT_W-1:0] flagged_count;
  logic [CNT_W-1:0] weighted_count;

  pwfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  pwfc_pixel_logic u_pix (
    .cfg       (cfg),
    .weight_in (s1_weight_r),
    .flag_in   (s1_flag_r),
    .res       (res)
  );

  pwfc_stat_counters u_cnt (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd            (upd),
    .area_hit       (res.area_hit),
    .limit_hit      (res.limit_hit),
    .last_pixel     (s1_last_r),
    .flagged_count  (flagged_count),
    .weighted_count (weighted_count)
  );

  // Stage enables
  assign out_adv      = !out_valid_r || out_bus.ready;
  assign s1_adv       = !s1_valid_r || out_adv;
  assign upd          = s1_valid_r && out_adv;
  assign in_bus.ready = s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_bus.valid) begin
      s1_weight_r <= in_bus.weight_in;
      s1_flag_r   <= in_bus.flag_in;
      s1_last_r   <= in_bus.last_pixel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_weight_r <= res.weight_out;
      out_flag_r   <= res.flag_out;
      out_fcnt_r   <= flagged_count;
      out_wcnt_r   <= weighted_count;
      out_done_r   <= s1_last_r;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.weight_out     = out_weight_r;
  assign out_bus.flag_out       = out_flag_r;
  assign out_bus.flagged_count  = out_fcnt_r;
  assign out_bus.weighted_count = out_wcnt_r;
  assign out_bus.image_done     = out_done_r;

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_adv |=> s1_valid_r && $stable(s1_weight_r) && $stable(s1_last_r))
    else $error("input stage lost a pending pixel");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_bus.ready)
    else $error("input stalled with empty stage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> out_valid_r)
    else $error("advanced pixel did not reach the result register");

endmodule

`default_nettype wire

// ----- rtl/pwfc_cfg_regs.sv -----
// Configuration register file of the combiner.
`default_nettype none

module pwfc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  pwfc_cfg_if.sink      cfg_bus,
  output pwfc_pkg::cfg_t cfg
);
  import pwfc_pkg::*;

  cfg_t cfg_r;

  // Always take a write transaction
  assign cfg_bus.ready = 1'b1;
  assign cfg = cfg_r;

  // Decode the index and update one register; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{thresh_high: {1'b0, {(WEIGHT_W-1){1'b1}}}, default: '0};
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_THRESH_LOW:       cfg_r.thresh_low       <= cfg_bus.data[WEIGHT_W-1:0];
        REG_THRESH_HIGH:      cfg_r.thresh_high      <= cfg_bus.data[WEIGHT_W-1:0];
        REG_REJECT_FLAG_MASK: cfg_r.reject_flag_mask <= cfg_bus.data[FLAG_OUT_W-1:0];
        REG_WEIGHT_ZERO_MASK: cfg_r.weight_zero_mask <= cfg_bus.data[FLAG_IN_W-1:0];
        REG_FLAG_SELECT_MASK: cfg_r.flag_select_mask <= cfg_bus.data[FLAG_IN_W-1:0];
        REG_REMAP_WORDS:
          cfg_r.remap_words <= cfg_bus.data[REMAP_SLOTS*FLAG_OUT_W-1:0];
        REG_AREA_FLAG_MASK:   cfg_r.area_flag_mask   <= cfg_bus.data[FLAG_OUT_W-1:0];
        REG_WEIGHT_LIMIT:     cfg_r.weight_limit     <= cfg_bus.data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pwfc_pixel_logic.sv -----
// Combinational weight range test, zeroing and flag remap for one pixel.
`default_nettype none

module pwfc_pixel_logic (
  input  pwfc_pkg::cfg_t                     cfg,
  input  logic signed [pwfc_pkg::WEIGHT_W-1:0] weight_in,
  input  logic [pwfc_pkg::FLAG_IN_W-1:0]     flag_in,
  output pwfc_pkg::pix_res_t                 res
);
  import pwfc_pkg::*;

  logic signed [WEIGHT_W-1:0] w;
  logic signed [WEIGHT_W-1:0] low;
  logic signed [WEIGHT_W-1:0] high;
  logic signed [WEIGHT_W-1:0] limit;
  logic signed [WEIGHT_W-1:0] wo;
  logic                       out_of_range;
  logic [FLAG_IN_W-1:0]       rem;
  logic [FLAG_IN_W-1:0]       slot;
  logic [FLAG_OUT_W-1:0]      fo;

  assign w     = weight_in;
  assign low   = cfg.thresh_low;
  assign high  = cfg.thresh_high;
  assign limit = cfg.weight_limit;

  // Range test and weight zeroing
  assign out_of_range = (w > high) || (w < low);
  assign wo = (out_of_range || ((flag_in & cfg.weight_zero_mask) != '0)) ? '0 : w;

  // Peel off the selected bits lowest first; slot k gets remap mask k
  always_comb begin
    rem  = cfg.flag_select_mask;
    slot = '0;
    fo   = out_of_range ? cfg.reject_flag_mask : '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      slot = rem & (~rem + 1'b1);
      if ((flag_in & slot) != '0) begin
        fo = fo | cfg.remap_words[k*FLAG_OUT_W +: FLAG_OUT_W];
      end
      rem = rem & ~slot;
    end
  end

  assign res.weight_out = wo;
  assign res.flag_out   = fo;
  assign res.area_hit   = (fo & cfg.area_flag_mask) != '0;
  assign res.limit_hit  = wo > limit;

endmodule

`default_nettype wire

// ----- rtl/pwfc_stat_counters.sv -----
// Saturating per-image counts of flagged pixels and pixels above the weight limit.
`default_nettype none

module pwfc_stat_counters (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic                        area_hit,
  input  logic                        limit_hit,
  input  logic                        last_pixel,
  output logic [pwfc_pkg::CNT_W-1:0]  flagged_count,
  output logic [pwfc_pkg::CNT_W-1:0]  weighted_count
);
  import pwfc_pkg::*;

  logic [CNT_W-1:0] flagged_total_r;
  logic [CNT_W-1:0] flagged_total_nxt;
  logic [CNT_W-1:0] weighted_total_r;
  logic [CNT_W-1:0] weighted_total_nxt;

  // Counts that include the current pixel, held at the maximum
  assign flagged_count  = (area_hit && flagged_total_r != CNT_MAX) ?
                          flagged_total_r + 1'b1 : flagged_total_r;
  assign weighted_count = (limit_hit && weighted_total_r != CNT_MAX) ?
                          weighted_total_r + 1'b1 : weighted_total_r;

  // Advance on each transaction, clear after the final pixel
  always_comb begin
    flagged_total_nxt  = flagged_total_r;
    weighted_total_nxt = weighted_total_r;
    if (upd) begin
      flagged_total_nxt  = last_pixel ? '0 : flagged_count;
      weighted_total_nxt = last_pixel ? '0 : weighted_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flagged_total_r  <= '0;
      weighted_total_r <= '0;
    end else begin
      flagged_total_r  <= flagged_total_nxt;
      weighted_total_r <= weighted_total_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    upd && last_pixel |=> flagged_total_r == '0 && weighted_total_r == '0)
    else $error("totals not cleared after final pixel");

  a_flagged_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    upd && !last_pixel && flagged_total_r == CNT_MAX |=> flagged_total_r == CNT_MAX)
    else $error("flagged total wrapped");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(flagged_total_r) && $stable(weighted_total_r))
    else $error("totals moved without a transaction");

endmodule

`default_nettype wire

// ----- bench/tb_pixel_weight_flag_combiner_top.sv -----
// Self-checking testbench for the pixel weight and flag combiner top level.
module tb_pixel_weight_flag_combiner_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pwfc_pkg::*;

  localparam int RAND_PHASES     = 10;
  localparam int PIXELS_PER_SET  = 115;
  localparam int IDLE_PERCENT    = 19;
  localparam int DIR_ROWS        = 18;

  // Indexes past the register file; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 8'hFF;

  typedef enum int {SET_RANDOM, SET_OPEN, SET_ALL_ONES, SET_ALL_ZERO} setting_kind_e;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [FLAG_OUT_W-1:0]      flag;
    logic [CNT_W-1:0]           flagged;
    logic [CNT_W-1:0]           weighted;
    logic                       done;
  } pixel_result_t;

  typedef struct packed {
    logic          fixed;
    pixel_result_t res;
  } typed_result_t;

  typedef struct {
    int                  phase;
    logic [WEIGHT_W-1:0] weight;
    logic [FLAG_IN_W-1:0] flag;
    logic                last;
    logic                fixed;
    logic [WEIGHT_W-1:0] exp_w;
    logic [FLAG_OUT_W-1:0] exp_f;
    logic [CNT_W-1:0]    exp_fc;
    logic [CNT_W-1:0]    exp_wc;
  } stim_row_t;

  logic clk;
  logic rst_n;
  bit   steady;

  pwfc_in_if  in_bus ();
  pwfc_out_if out_bus ();
  pwfc_cfg_if cfg_bus ();

  pixel_weight_flag_combiner_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Predictor state: register copy and running totals
  cfg_t             model_regs;
  logic [CNT_W-1:0] flagged_total;
  logic [CNT_W-1:0] weighted_total;

  // Stimulus-side copy of the last loaded settings
  cfg_t loaded_regs;

  pixel_result_t expected_pixels_q [$];
  typed_result_t table_results_q [$];

  int fail_count;
  int results_checked;
  int pixels_sent;
  int images_sent;
  int settings_loaded;

  // Directed settings; entry 0 is the reset state
  cfg_t dir_settings [3] = '{
    '{32'h00000000, 32'h7FFFFFFF, 16'h0000, 31'h0, 31'h0, 64'h0, 16'h0000, 32'h0},
    '{32'hFFFF0000, 32'h00020000, 16'h8000, 31'h40000000, 31'h40001221,
      64'h0F00_00F0_000F_1000, 16'h8001, 32'h00008000},
    '{32'h00010000, 32'h0000FFFF, 16'hFFFF, 31'h0, 31'h7FFFFFFF,
      64'hFFFF_0000_8000_0001, 16'hFFFF, 32'h80000000}
  };

  // Directed pixels; rows with fixed set carry their result inline
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{0, 32'h00000000, 31'h0,        1'b0, 1'b1, 32'h00000000, 16'h0, 32'd0, 32'd0},
    '{0, 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, 1'b1, 32'h7FFFFFFF, 16'h0, 32'd0, 32'd1},
    '{0, 32'h80000000, 31'h0,        1'b1, 1'b1, 32'h00000000, 16'h0, 32'd0, 32'd1},
    '{0, 32'h00010000, 31'h0,        1'b1, 1'b1, 32'h00010000, 16'h0, 32'd0, 32'd1},
    '{1, 32'hFFFF0000, 31'h0,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h00020000, 31'h1,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h00020001, 31'h0,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'hFFFEFFFF, 31'h0,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h00010000, 31'h40000000, 1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h00010000, 31'h00001221, 1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h00008000, 31'h0,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h00008001, 31'h7FFFFFFF, 1'b1, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h7FFFFFFF, 31'h0,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{1, 32'h80000000, 31'h0,        1'b1, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{2, 32'h0000FFFF, 31'h0,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{2, 32'h00010000, 31'h0,        1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{2, 32'h00000000, 31'h0000000F, 1'b0, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0},
    '{2, 32'hFFFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b0, 32'h0, 16'h0, 32'd0, 32'd0}
  };

  // Compute the combined pixel and advance the running totals
  function automatic pixel_result_t combine_pixel(logic signed [WEIGHT_W-1:0] w,
                                                  logic [FLAG_IN_W-1:0] f, logic last);
    pixel_result_t         r;
    logic                  reject;
    logic signed [WEIGHT_W-1:0] wo;
    logic [FLAG_OUT_W-1:0] fo;
    int                    rank;
    reject = (w > $signed(model_regs.thresh_high)) || (w < $signed(model_regs.thresh_low));
    wo = reject ? '0 : w;
    if ((f & model_regs.weight_zero_mask) != '0) wo = '0;
    fo = reject ? model_regs.reject_flag_mask : '0;
    rank = 0;
    for (int j = 0; j < FLAG_IN_W; j++) begin
      if (model_regs.flag_select_mask[j]) begin
        if (rank < NUM_SLOTS && f[j]) fo |= model_regs.remap_words[rank*FLAG_OUT_W +: FLAG_OUT_W];
        rank++;
      end
    end
    if ((fo & model_regs.area_flag_mask) != '0 && flagged_total != CNT_MAX)
      flagged_total++;
    if (wo > $signed(model_regs.weight_limit) && weighted_total != CNT_MAX)
      weighted_total++;
    r.weight   = wo;
    r.flag     = fo;
    r.flagged  = flagged_total;
    r.weighted = weighted_total;
    r.done     = last;
    if (last) begin
      flagged_total  = '0;
      weighted_total = '0;
    end
    return r;
  endfunction

  // Apply one register write to the predictor copy
  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_THRESH_LOW:       model_regs.thresh_low       = d[WEIGHT_W-1:0];
      REG_THRESH_HIGH:      model_regs.thresh_high      = d[WEIGHT_W-1:0];
      REG_REJECT_FLAG_MASK: model_regs.reject_flag_mask = d[FLAG_OUT_W-1:0];
      REG_WEIGHT_ZERO_MASK: model_regs.weight_zero_mask = d[FLAG_IN_W-1:0];
      REG_FLAG_SELECT_MASK: model_regs.flag_select_mask = d[FLAG_IN_W-1:0];
      REG_REMAP_WORDS:      model_regs.remap_words      = d;
      REG_AREA_FLAG_MASK:   model_regs.area_flag_mask   = d[FLAG_OUT_W-1:0];
      REG_WEIGHT_LIMIT:     model_regs.weight_limit     = d[WEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result sink stalls at random, except during the steady stretch
  always @(posedge clk) begin
    out_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Track register writes, predict accepted pixels, check results
  always @(posedge clk) begin
    pixel_result_t exp_r;
    typed_result_t pin;
    if (!rst_n) begin
      model_regs     = dir_settings[0];
      flagged_total  = '0;
      weighted_total = '0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_pixels_q.size() == 0) begin
          $error("result with no pixel pending: weight %h flag %h",
                 out_bus.weight_out, out_bus.flag_out);
          fail_count++;
        end else begin
          exp_r = expected_pixels_q.pop_front();
          check_field("weight_out", exp_r.weight, out_bus.weight_out);
          check_field("flag_out", 32'(exp_r.flag), 32'(out_bus.flag_out));
          check_field("flagged_count", exp_r.flagged, out_bus.flagged_count);
          check_field("weighted_count", exp_r.weighted, out_bus.weighted_count);
          check_field("image_done", 32'(exp_r.done), 32'(out_bus.image_done));
          results_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        exp_r = combine_pixel(in_bus.weight_in, in_bus.flag_in, in_bus.last_pixel);
        pin = table_results_q.pop_front();
        expected_pixels_q.push_back(pin.fixed ? pin.res : exp_r);
      end
      if (cfg_bus.valid && cfg_bus.ready) apply_reg_write(cfg_bus.index, cfg_bus.data);
    end
  end

  // Present one pixel and hold it until the transaction completes
  task automatic send_pixel(logic [WEIGHT_W-1:0] w, logic [FLAG_IN_W-1:0] f, logic last,
                            logic fixed, pixel_result_t res);
    typed_result_t pin;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pin.fixed = fixed;
    pin.res   = res;
    table_results_q.push_back(pin);
    in_bus.valid      <= 1'b1;
    in_bus.weight_in  <= w;
    in_bus.flag_in    <= f;
    in_bus.last_pixel <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pixels_sent++;
    if (last) images_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value, int width);
    logic [CFG_DATA_W-1:0] keep;
    keep = (width >= CFG_DATA_W) ? '1 : ((64'd1 << width) - 64'd1);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    // Junk above the register width must be dropped by the block
    cfg_bus.data  <= ({$urandom, $urandom} & ~keep) | (value & keep);
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
  endtask

  task automatic load_settings(cfg_t s, bit stray);
    write_reg(REG_THRESH_LOW, 64'(s.thresh_low), WEIGHT_W);
    write_reg(REG_THRESH_HIGH, 64'(s.thresh_high), WEIGHT_W);
    write_reg(REG_REJECT_FLAG_MASK, 64'(s.reject_flag_mask), FLAG_OUT_W);
    write_reg(REG_WEIGHT_ZERO_MASK, 64'(s.weight_zero_mask), FLAG_IN_W);
    write_reg(REG_FLAG_SELECT_MASK, 64'(s.flag_select_mask), FLAG_IN_W);
    write_reg(REG_REMAP_WORDS, s.remap_words, CFG_DATA_W);
    write_reg(REG_AREA_FLAG_MASK, 64'(s.area_flag_mask), FLAG_OUT_W);
    write_reg(REG_WEIGHT_LIMIT, 64'(s.weight_limit), WEIGHT_W);
    if (stray) begin
      write_reg(REG_UNMAPPED_FIRST, {$urandom, $urandom}, CFG_DATA_W);
      write_reg(REG_UNMAPPED_LAST, {$urandom, $urandom}, CFG_DATA_W);
    end
    cfg_bus.valid <= 1'b0;
    loaded_regs = s;
    settings_loaded++;
  endtask

  // Hold off input until every pending result has been checked
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (expected_pixels_q.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [FLAG_IN_W-1:0] sparse_bits(int n);
    logic [FLAG_IN_W-1:0] m;
    m = '0;
    repeat (n) m[$urandom_range(0, FLAG_IN_W-1)] = 1'b1;
    return m;
  endfunction

  // Q16.16 value in [-4.0, 4.0]
  function automatic logic [WEIGHT_W-1:0] narrow_q16();
    return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
  endfunction

  function automatic logic [WEIGHT_W-1:0] near_value(logic [WEIGHT_W-1:0] v);
    return v + 32'($urandom_range(0, 4)) - 32'd2;
  endfunction

  function automatic cfg_t pick_settings(setting_kind_e kind);
    cfg_t                s;
    logic [WEIGHT_W-1:0] a;
    logic [WEIGHT_W-1:0] b;
    a = narrow_q16();
    b = narrow_q16();
    // Mostly ordered thresholds; some crossed, some anywhere
    if ($urandom_range(0, 5) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
    if ($urandom_range(0, 7) == 0) {a, b} = {$urandom, $urandom};
    s.thresh_low       = a;
    s.thresh_high      = b;
    s.reject_flag_mask = 16'($urandom);
    s.weight_zero_mask = sparse_bits($urandom_range(0, 2));
    s.flag_select_mask = ($urandom_range(0, 5) == 0) ? 31'($urandom)
                                                     : sparse_bits($urandom_range(0, 6));
    s.remap_words      = {$urandom, $urandom};
    s.area_flag_mask   = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
    s.weight_limit     = narrow_q16();
    case (kind)
      SET_OPEN: begin
        s.thresh_low   = 32'h80000000;
        s.thresh_high  = 32'h7FFFFFFF;
        s.weight_limit = 32'h80000000;
      end
      SET_ALL_ONES: begin
        s.thresh_low       = 32'h7FFFFFFF;
        s.thresh_high      = 32'h80000000;
        s.reject_flag_mask = '1;
        s.weight_zero_mask = '1;
        s.flag_select_mask = '1;
        s.remap_words      = '1;
        s.area_flag_mask   = '1;
        s.weight_limit     = 32'h7FFFFFFF;
      end
      SET_ALL_ZERO: begin
        s.thresh_low       = '0;
        s.thresh_high      = '0;
        s.reject_flag_mask = '0;
        s.weight_zero_mask = '0;
        s.flag_select_mask = '0;
        s.remap_words      = '0;
        s.area_flag_mask   = '0;
        s.weight_limit     = '0;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic setting_kind_e kind_of_phase(int p);
    case (p)
      0:       return SET_OPEN;
      1:       return SET_ALL_ONES;
      4:       return SET_ALL_ZERO;
      default: return SET_RANDOM;
    endcase
  endfunction

  // Stimulus: reset, directed rows, then random phases
  initial begin
    pixel_result_t        row_res;
    logic [WEIGHT_W-1:0]  w;
    logic [FLAG_IN_W-1:0] f;
    int                   cur_phase;
    fail_count      = 0;
    results_checked = 0;
    pixels_sent     = 0;
    images_sent     = 0;
    settings_loaded = 0;
    steady          = 1'b0;
    rst_n           = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.weight_in  = '0;
    in_bus.flag_in    = '0;
    in_bus.last_pixel = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    loaded_regs       = dir_settings[0];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows, reloading settings when the phase changes
    cur_phase = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].phase != cur_phase) begin
        drain();
        cur_phase = dir_rows[i].phase;
        load_settings(dir_settings[cur_phase], cur_phase == 1);
      end
      row_res = '{dir_rows[i].exp_w, dir_rows[i].exp_f, dir_rows[i].exp_fc,
                  dir_rows[i].exp_wc, dir_rows[i].last};
      send_pixel(dir_rows[i].weight, dir_rows[i].flag, dir_rows[i].last,
                 dir_rows[i].fixed, row_res);
    end

    // Random phases, one settings load each; phase 3 runs without idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      load_settings(pick_settings(kind_of_phase(p)), p == 2);
      steady <= (p == 3);
      repeat (PIXELS_PER_SET) begin
        case ($urandom_range(0, 6))
          0, 1:    w = $urandom;
          2:       w = near_value(loaded_regs.thresh_low);
          3:       w = near_value(loaded_regs.thresh_high);
          4:       w = near_value(loaded_regs.weight_limit);
          5:       w = narrow_q16();
          default: begin
            case ($urandom_range(0, 2))
              0:       w = 32'h80000000;
              1:       w = 32'h7FFFFFFF;
              default: w = 32'h0;
            endcase
          end
        endcase
        case ($urandom_range(0, 3))
          0:       f = 31'($urandom);
          1:       f = loaded_regs.flag_select_mask & 31'($urandom);
          2:       f = ((loaded_regs.flag_select_mask | loaded_regs.weight_zero_mask)
                        & 31'($urandom)) | sparse_bits(1);
          default: f = '0;
        endcase
        send_pixel(w, f, $urandom_range(0, 19) == 0, 1'b0, '0);
      end
    end

    // Let stray results show up before closing
    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d pixels in %0d images across %0d register settings,",
             pixels_sent, images_sent, settings_loaded);
    $display("with %0d results checked field by field.", results_checked);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pwfc_pkg.sv
rtl/pwfc_if.sv
rtl/pwfc_cfg_regs.sv
rtl/pwfc_pixel_logic.sv
rtl/pwfc_stat_counters.sv
rtl/pixel_weight_flag_combiner_top.sv
bench/tb_pixel_weight_flag_combiner_top.sv
